FILE: hw/rtl/mesm_pkg.sv
// Shared types and codes for the MIDI event store and merge block.
// Used by mesm_ctrl, mesm_dp and midi_event_store_merge; no dependencies.
package mesm_pkg;

    localparam int DEF_STORE_DEPTH = 256;

    localparam int TS_W    = 32;
    localparam int CHAN_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int FUNC_W  = 3;
    localparam int CODE_W  = 2;
    localparam int COUNT_W = 9;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;

    // request kinds
    localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ERASE    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MERGE    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd4;

    // result codes
    localparam logic [CODE_W-1:0] CODE_OK       = 2'd0;
    localparam logic [CODE_W-1:0] CODE_FULL     = 2'd1;
    localparam logic [CODE_W-1:0] CODE_RANGE    = 2'd2;
    localparam logic [CODE_W-1:0] CODE_REJECTED = 2'd3;

    // MIDI opcode nibbles
    localparam logic [3:0] OP_NOTE_ON  = 4'h9;
    localparam logic [3:0] OP_NOTE_OFF = 4'h8;

    typedef struct packed {
        logic [TS_W-1:0]   ts;
        logic [BYTE_W-1:0] st;
        logic [BYTE_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic load;
        logic note_wr;
        logic walk_start;
        logic erase_step;
        logic erase_end;
        logic copy_step;
        logic copy_end;
        logic snap_cmp;
        logic item_put;
        logic merge_end;
        logic rd_issue;
        logic rd_capture;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic merging;
        logic walk_busy;
        logic snap_more;
        logic take_snap;
        logic last;
        logic drain;
        logic out_busy;
    } t_sts;

endpackage

FILE: hw/rtl/midi_event_store_merge.sv
// MIDI event store with erase-by-channel and in-order streaming merge.
// Channels: a request stream (tdata: event time, channel, note, status_in,
// index from bit 0 up; tuser: func; tlast: last merge item) and a result
// stream (tdata: count, read time, read_status, read_note from bit 0
// up; tuser: status_code). Every request yields exactly one result.
// One request is in work at a time; tready is high only while idle.
// Erase walks the store one entry per cycle through the single memory
// read port; the first item of a merge first copies the store into the
// snapshot, and each merge item moves out the snapshot entries with an
// earlier time (read, then compare) before it is written. The last merge
// item also drains the rest of the snapshot. The result turns valid at
// the same edge as tready returns.
// The result sits in an output register; the next request is taken while
// it waits, and finishing that request waits for the register to be free.
// Reset clears counters, the merge flag and the result valid; memory
// contents are left as they are and are only read below the entry count.
// Depends on mesm_pkg, mesm_ctrl and mesm_dp.
module midi_event_store_merge
    import mesm_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // event time, channel, note, status_in, index
    input  logic [FUNC_W-1:0]      s_axis_tuser,  // func
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // count, read time, read_status, read_note
    output logic [CODE_W-1:0]      m_axis_tuser   // status_code
);

    t_cmd cmd;
    t_sts sts;

    mesm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    mesm_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_func   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_code  (m_axis_tuser)
    );

endmodule

FILE: hw/rtl/mesm_ctrl.sv
// Sequencer for the MIDI event store: steps each request through its phases.
// Depends on mesm_pkg; drives mesm_dp through t_cmd and watches t_sts.
module mesm_ctrl
    import mesm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_ERASE = 4'd2;
    localparam logic [3:0] S_COPY  = 4'd3;
    localparam logic [3:0] S_MRD   = 4'd4;
    localparam logic [3:0] S_MCMP  = 4'd5;
    localparam logic [3:0] S_MEND  = 4'd6;
    localparam logic [3:0] S_RDCAP = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.func)
                    FUNC_NOTE_ON, FUNC_NOTE_OFF: begin
                        o_cmd.note_wr = 1'b1;
                        n_state       = S_FIN;
                    end
                    FUNC_ERASE: begin
                        if (i_sts.merging) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_ERASE;
                        end
                    end
                    FUNC_MERGE: begin
                        if (i_sts.merging) begin
                            n_state = S_MRD;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_COPY;
                        end
                    end
                    FUNC_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_RDCAP;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_ERASE: begin
                o_cmd.erase_step = 1'b1;
                if (!i_sts.walk_busy) begin
                    o_cmd.erase_end = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (!i_sts.walk_busy) begin
                    o_cmd.copy_end = 1'b1;
                    n_state        = S_MRD;
                end
            end
            S_MRD: begin
                if (i_sts.snap_more) begin
                    n_state = S_MCMP;
                end else if (i_sts.drain) begin
                    n_state = S_MEND;
                end else begin
                    o_cmd.item_put = 1'b1;
                    n_state        = i_sts.last ? S_MRD : S_MEND;
                end
            end
            S_MCMP: begin
                if (i_sts.take_snap) begin
                    o_cmd.snap_cmp = 1'b1;
                    n_state        = S_MRD;
                end else begin
                    o_cmd.item_put = 1'b1;
                    n_state        = i_sts.last ? S_MRD : S_MEND;
                end
            end
            S_MEND: begin
                o_cmd.merge_end = 1'b1;
                n_state         = S_FIN;
            end
            S_RDCAP: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/mesm_dp.sv
// Datapath of the MIDI event store: message and snapshot memories, pointers,
// request capture and result register. Depends on mesm_pkg; driven by mesm_ctrl.
module mesm_dp
    import mesm_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic [FUNC_W-1:0]      i_in_func,
    input  logic                   i_in_last,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic [CODE_W-1:0]      o_out_code
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    // request fields
    logic [FUNC_W-1:0] r_func;
    logic [TS_W-1:0]   r_ts;
    logic [CHAN_W-1:0] r_chan;
    logic [BYTE_W-1:0] r_note;
    logic [BYTE_W-1:0] r_stin;
    logic              r_last;
    logic [BYTE_W-1:0] r_index;

    logic [CW-1:0] r_count, r_scount, r_sp, r_wp, r_rp, r_ep;
    logic [AW-1:0] r_raddr;
    logic          r_rvld, r_merging, r_drain;
    logic [CODE_W-1:0] r_code;
    t_entry        r_rd_entry;

    logic          r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic [COUNT_W-1:0] r_out_count;
    t_entry        r_out_entry;

    t_entry mem [STORE_DEPTH];
    t_entry snap [STORE_DEPTH];
    t_entry mem_rdata, snap_rdata;

    logic          mem_we, snap_we;
    logic [AW-1:0] mem_wa, mem_ra, snap_wa, snap_ra;
    t_entry        mem_wd, item, put_entry;
    logic          take, put_req, walking, rd_ok;

    assign item    = '{ts: r_ts, st: r_stin, data: r_note};
    assign take    = r_drain || (snap_rdata.ts < r_ts);
    assign walking = i_cmd.erase_step || i_cmd.copy_step;
    assign put_req = i_cmd.item_put || (i_cmd.snap_cmp && take);
    assign put_entry = i_cmd.item_put ? item : snap_rdata;
    assign rd_ok   = (32'(r_index) < 32'(r_count));

    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_count[AW-1:0];
        mem_wd  = put_entry;
        mem_ra  = r_rp[AW-1:0];
        snap_we = 1'b0;
        snap_wa = r_raddr;
        snap_ra = r_sp[AW-1:0];
        if (i_cmd.note_wr && !r_merging && r_count < DEPTH_C) begin
            mem_we = 1'b1;
            mem_wd = '{ts: r_ts,
                       st: {(r_func == FUNC_NOTE_ON) ? OP_NOTE_ON : OP_NOTE_OFF, r_chan},
                       data: r_note};
        end
        if (i_cmd.erase_step && r_rvld && mem_rdata.st[3:0] != r_chan) begin
            mem_we = 1'b1;
            mem_wa = r_ep[AW-1:0];
            mem_wd = mem_rdata;
        end
        if (i_cmd.copy_step && r_rvld) begin
            snap_we = 1'b1;
        end
        if (put_req && r_wp < DEPTH_C) begin
            mem_we = 1'b1;
            mem_wa = r_wp[AW-1:0];
            mem_wd = put_entry;
        end
        if (i_cmd.rd_issue) begin
            mem_ra = AW'(32'(r_index));
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (snap_we) begin
            snap[snap_wa] <= mem_rdata;
        end
        snap_rdata <= snap[snap_ra];
    end

    // request capture and read fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_in_func;
            r_last  <= i_in_last;
            r_ts    <= i_in_data[TS_W-1:0];
            r_chan  <= i_in_data[TS_W +: CHAN_W];
            r_note  <= i_in_data[TS_W+CHAN_W +: BYTE_W];
            r_stin  <= i_in_data[TS_W+CHAN_W+BYTE_W +: BYTE_W];
            r_index <= i_in_data[TS_W+CHAN_W+2*BYTE_W +: BYTE_W];
            r_rd_entry <= '0;
        end else if (i_cmd.rd_capture && rd_ok) begin
            r_rd_entry <= mem_rdata;
        end
        if (walking) begin
            r_raddr <= r_rp[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_scount  <= '0;
            r_sp      <= '0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_ep      <= '0;
            r_rvld    <= 1'b0;
            r_merging <= 1'b0;
            r_drain   <= 1'b0;
            r_code    <= CODE_OK;
        end else begin
            if (i_cmd.load) begin
                r_code <= (r_merging && (i_in_func == FUNC_NOTE_ON
                                         || i_in_func == FUNC_NOTE_OFF
                                         || i_in_func == FUNC_ERASE))
                          ? CODE_REJECTED : CODE_OK;
            end
            if (i_cmd.note_wr && !r_merging) begin
                if (r_count < DEPTH_C) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_code <= CODE_FULL;
                end
            end
            if (i_cmd.walk_start) begin
                r_rp   <= '0;
                r_ep   <= '0;
                r_rvld <= 1'b0;
            end
            if (walking) begin
                // issue the next read while handling the previous one
                r_rvld <= (r_rp < r_count);
                if (r_rp < r_count) begin
                    r_rp <= r_rp + CW'(1);
                end
            end
            if (i_cmd.erase_step && r_rvld && mem_rdata.st[3:0] != r_chan) begin
                r_ep <= r_ep + CW'(1);
            end
            if (i_cmd.erase_end) begin
                r_count <= r_ep;
            end
            if (i_cmd.copy_end) begin
                r_scount  <= r_count;
                r_sp      <= '0;
                r_wp      <= '0;
                r_merging <= 1'b1;
            end
            if (i_cmd.snap_cmp) begin
                r_sp <= r_sp + CW'(1);
            end
            if (put_req) begin
                if (r_wp < DEPTH_C) begin
                    r_wp <= r_wp + CW'(1);
                end else begin
                    r_code <= CODE_FULL;
                end
            end
            if (i_cmd.item_put && r_last) begin
                r_drain <= 1'b1;
            end
            if (i_cmd.merge_end) begin
                r_count <= r_wp;
                if (r_drain) begin
                    r_drain   <= 1'b0;
                    r_merging <= 1'b0;
                end
            end
            if (i_cmd.rd_capture && !rd_ok) begin
                r_code <= CODE_RANGE;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_code  <= r_code;
            r_out_count <= COUNT_W'(r_count);
            r_out_entry <= r_rd_entry;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_code  = r_out_code;
    assign o_out_data  = {{(OUT_TDATA_W - COUNT_W - TS_W - 2*BYTE_W){1'b0}},
                          r_out_entry.data, r_out_entry.st, r_out_entry.ts, r_out_count};

    assign o_sts.func      = r_func;
    assign o_sts.merging   = r_merging;
    assign o_sts.walk_busy = (r_rp < r_count) || r_rvld;
    assign o_sts.snap_more = (r_sp < r_scount);
    assign o_sts.take_snap = take;
    assign o_sts.last      = r_last;
    assign o_sts.drain     = r_drain;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

endmodule

FILE: tb/midi_event_store_merge_test.sv
// Testbench for midi_event_store_merge: drives note, erase, merge and read
// requests and checks every result against a behavioral store model.
// Depends on mesm_pkg and the midi_event_store_merge RTL.
`timescale 1ns / 100ps

import mesm_pkg::*;

class store_scoreboard;
    t_entry      store_q[$];
    t_entry      snap_q[$];
    int unsigned snap_ptr;
    bit          merging;
    logic [COUNT_W-1:0] cnt_q[$];
    logic [TS_W-1:0]    ts_q[$];
    logic [BYTE_W-1:0]  st_q[$];
    logic [BYTE_W-1:0]  nt_q[$];
    logic [CODE_W-1:0]  code_q[$];
    int errors;
    int depth;

    function new(int d);
        depth = d;
        errors = 0;
        merging = 0;
        snap_ptr = 0;
    endfunction

    function bit put_entry(t_entry e);
        if (store_q.size() >= depth) return 0;
        store_q.push_back(e);
        return 1;
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [TS_W-1:0] ts,
                               logic [CHAN_W-1:0] ch, logic [BYTE_W-1:0] nb,
                               logic [BYTE_W-1:0] st_in, logic lst,
                               logic [BYTE_W-1:0] idx);
        t_entry e;
        t_entry kept[$];
        logic [CODE_W-1:0] code;
        logic [TS_W-1:0] rts;
        logic [BYTE_W-1:0] rst, rnt;
        code = CODE_OK;
        rts = '0; rst = '0; rnt = '0;
        case (func)
            FUNC_NOTE_ON, FUNC_NOTE_OFF: begin
                if (merging) begin
                    code = CODE_REJECTED;
                end else begin
                    e.ts = ts;
                    e.st = {(func == FUNC_NOTE_ON) ? OP_NOTE_ON : OP_NOTE_OFF, ch};
                    e.data = nb;
                    if (!put_entry(e)) code = CODE_FULL;
                end
            end
            FUNC_ERASE: begin
                if (merging) begin
                    code = CODE_REJECTED;
                end else begin
                    foreach (store_q[i])
                        if (store_q[i].st[3:0] != ch) kept.push_back(store_q[i]);
                    store_q = kept;
                end
            end
            FUNC_MERGE: begin
                if (!merging) begin
                    snap_q = store_q;
                    store_q.delete();
                    snap_ptr = 0;
                    merging = 1;
                end
                while (snap_ptr < snap_q.size() && snap_q[snap_ptr].ts < ts) begin
                    if (!put_entry(snap_q[snap_ptr])) code = CODE_FULL;
                    snap_ptr++;
                end
                e.ts = ts; e.st = st_in; e.data = nb;
                if (!put_entry(e)) code = CODE_FULL;
                if (lst) begin
                    while (snap_ptr < snap_q.size()) begin
                        if (!put_entry(snap_q[snap_ptr])) code = CODE_FULL;
                        snap_ptr++;
                    end
                    merging = 0;
                end
            end
            FUNC_READ: begin
                if (idx < store_q.size()) begin
                    rts = store_q[idx].ts; rst = store_q[idx].st; rnt = store_q[idx].data;
                end else begin
                    code = CODE_RANGE;
                end
            end
            default: ;
        endcase
        code_q.push_back(code);
        cnt_q.push_back(COUNT_W'(store_q.size()));
        ts_q.push_back(rts);
        st_q.push_back(rst);
        nt_q.push_back(rnt);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic [CODE_W-1:0] code);
        logic [COUNT_W-1:0] ec;
        logic [TS_W-1:0] ets;
        logic [BYTE_W-1:0] est, ent;
        logic [CODE_W-1:0] ecode;
        if (code_q.size() == 0) begin
            $display("%0t: unexpected result tdata=%h tuser=%0d", $time, d, code);
            errors++;
            return;
        end
        ecode = code_q.pop_front(); ec = cnt_q.pop_front();
        ets = ts_q.pop_front(); est = st_q.pop_front(); ent = nt_q.pop_front();
        if (code !== ecode) begin
            $display("%0t: status_code exp %0d got %0d", $time, ecode, code); errors++;
        end
        if (d[8:0] !== ec) begin
            $display("%0t: count exp %0d got %0d", $time, ec, d[8:0]); errors++;
        end
        if (d[40:9] !== ets) begin
            $display("%0t: read time exp %h got %h", $time, ets, d[40:9]); errors++;
        end
        if (d[48:41] !== est) begin
            $display("%0t: read_status exp %h got %h", $time, est, d[48:41]); errors++;
        end
        if (d[56:49] !== ent) begin
            $display("%0t: read_note exp %h got %h", $time, ent, d[56:49]); errors++;
        end
        if (d[63:57] !== '0) begin
            $display("%0t: tdata pad exp 0 got %h", $time, d[63:57]); errors++;
        end
    endfunction

    function int pending();
        return code_q.size();
    endfunction
endclass

module midi_event_store_merge_test;
    import mesm_pkg::*;

    localparam int DEPTH = 256;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [FUNC_W-1:0] s_axis_tuser = '0;
    logic s_axis_tlast = 0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [CODE_W-1:0] m_axis_tuser;

    store_scoreboard board;
    bit calm;
    int idle_cycles = 0;

    midi_event_store_merge #(.STORE_DEPTH(DEPTH)) i_dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic bit take_gap();
        return !calm && ($urandom_range(99) < 38);
    endfunction

    // Result side: random backpressure, check on every accepted result; accepted requests feed the model.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[35:32],
                               s_axis_tdata[43:36], s_axis_tdata[51:44], s_axis_tlast,
                               s_axis_tdata[59:52]);
        m_axis_tready <= !take_gap();
    end

    // Watchdog on handshake activity.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Hold valid across back-to-back requests; drop it only for an idle gap.
    task automatic send(logic [FUNC_W-1:0] func, logic [TS_W-1:0] ts,
                        logic [CHAN_W-1:0] ch, logic [BYTE_W-1:0] nb,
                        logic [BYTE_W-1:0] st_in, logic lst, logic [BYTE_W-1:0] idx);
        while (take_gap()) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= func;
        s_axis_tlast  <= lst;
        s_axis_tdata  <= {4'h0, idx, st_in, nb, ch, ts};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [TS_W-1:0] rand_ts();
        case ($urandom_range(3))
            0: return $urandom_range(20);
            1: return '1 - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_idx();
        int n;
        n = board.store_q.size();
        if (n > 0 && $urandom_range(3) != 0) return $urandom_range(n - 1);
        return $urandom;
    endfunction

    // Merge a sorted list of random length into the store, with reads and note or erase requests mixed in.
    task automatic merge_run(int len);
        logic [TS_W-1:0] t;
        t = $urandom_range(50);
        for (int k = 0; k < len; k++) begin
            send(FUNC_MERGE, t, $urandom, $urandom, $urandom, k == len - 1, $urandom);
            if ($urandom_range(4) == 0) send(FUNC_READ, 0, 0, 0, 0, 0, rand_idx());
            if ($urandom_range(9) == 0)
                send($urandom_range(2), $urandom, $urandom, 0, 0, 0, 0);
            t = t + $urandom_range(30);
        end
    endtask

    initial begin
        int sent;
        board = new(DEPTH);
        calm = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty reads, each op, extremes, ties in a merge, unused codes.
        send(FUNC_READ, 0, 0, 0, 0, 0, 8'hFF);
        send(FUNC_NOTE_ON, 32'hFFFF_FFFF, 4'hF, 8'hFF, 0, 1, 8'hFF);
        send(FUNC_NOTE_OFF, 0, 0, 0, 8'hFF, 0, 0);
        send(FUNC_NOTE_ON, 10, 4'h3, 8'h40, 0, 0, 0);
        send(FUNC_READ, 0, 0, 0, 0, 0, 0);
        send(FUNC_READ, 0, 0, 0, 0, 0, 2);
        send(FUNC_READ, 0, 0, 0, 0, 0, 3);
        send(3'd5, 5, 1, 1, 1, 1, 1);
        send(3'd6, 0, 0, 0, 0, 0, 0);
        send(3'd7, '1, '1, '1, '1, 1, '1);
        send(FUNC_MERGE, 0, 0, 8'h11, 8'h90, 0, 0);
        send(FUNC_NOTE_ON, 1, 1, 1, 0, 0, 0);
        send(FUNC_ERASE, 0, 4'h3, 0, 0, 0, 0);
        send(FUNC_READ, 0, 0, 0, 0, 0, 0);
        send(FUNC_MERGE, 10, 0, 8'h22, 8'h83, 0, 0);
        send(FUNC_MERGE, 32'hFFFF_FFFF, 0, 8'h33, 8'hFF, 1, 0);
        for (int i = 0; i < 5; i++) send(FUNC_READ, 0, 0, 0, 0, 0, i);
        send(FUNC_ERASE, 0, 4'hF, 0, 0, 0, 0);
        send(FUNC_ERASE, 0, 4'h3, 0, 0, 0, 0);
        send(FUNC_READ, 0, 0, 0, 0, 0, 0);
        sent = 25;

        // Random: mostly appends, merges and reads; occasional full store.
        while (sent < 500) begin
            calm = (sent >= 200 && sent < 260);
            case ($urandom_range(9))
                0, 1, 2: begin
                    send($urandom_range(1), rand_ts(), $urandom, $urandom, $urandom,
                         $urandom, $urandom);
                    sent++;
                end
                3: begin
                    send(FUNC_ERASE, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
                    sent++;
                end
                4, 5: begin
                    int len;
                    len = $urandom_range(1, 6);
                    merge_run(len);
                    sent += len;
                end
                6: begin
                    // Fill toward capacity so drops are exercised.
                    if ($urandom_range(3) == 0)
                        repeat (60) begin
                            send(FUNC_NOTE_ON, $urandom, $urandom, $urandom, 0, 0, 0);
                            sent++;
                        end
                end
                7: begin
                    send($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
                    sent++;
                end
                default: begin
                    send(FUNC_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                         rand_idx());
                    sent++;
                end
            endcase
        end
        // Close any open merge.
        if (board.merging) send(FUNC_MERGE, '1, 0, 0, 0, 1, 0);
        s_axis_tvalid <= 0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/mesm_pkg.sv
hw/rtl/mesm_ctrl.sv
hw/rtl/mesm_dp.sv
hw/rtl/midi_event_store_merge.sv
tb/midi_event_store_merge_test.sv
